// ===== src/ffsn_pkg.sv =====
// Shared types, character codes and constants of the fixed-form source normalizer.
package ffsn_pkg;

	localparam int LABEL_COLUMNS = 5;
	localparam int MAX_RES = 3;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	// line phases
	localparam logic [2:0] PH_LABEL = 3'd0;
	localparam logic [2:0] PH_CONT = 3'd1;
	localparam logic [2:0] PH_SKIP = 3'd2;
	localparam logic [2:0] PH_CODE = 3'd3;
	localparam logic [2:0] PH_IGNORE = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_CODE = 2'd0;
	localparam logic [1:0] KIND_NEWLINE = 2'd1;
	localparam logic [1:0] KIND_LABEL = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_BAD_LABEL = 2'd1;
	localparam logic [1:0] ERR_LABEL_BIG = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_COLUMN_LIMIT = 2'd0;
	localparam logic [1:0] REG_TAB_FORM = 2'd1;
	localparam logic [1:0] REG_DEBUG_LINES = 2'd2;

	localparam logic [7:0] COLUMN_LIMIT_RST = 8'd72;

	// characters
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_UC = 8'h43;
	localparam logic [7:0] CH_UD = 8'h44;
	localparam logic [7:0] CH_UH = 8'h48;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LC = 8'h63;
	localparam logic [7:0] CH_LD = 8'h64;
	localparam logic [7:0] CH_LH = 8'h68;
	localparam logic [7:0] NEWLINE_BYTE = CH_LF;

	typedef struct packed {
		logic [7:0] column;
		logic [2:0] phase;
		logic [31:0] label_accum;
		logic label_seen;
		logic cont;
		logic [7:0] delim;
		logic esc;
		logic [31:0] hcount;
		logic hovf;
		logic [31:0] hrem;
		logic first;
		logic halted;
		logic live;
	} st_t;

	localparam st_t ST_CLEAR = '{
		column: 8'd0, phase: PH_LABEL, label_accum: 32'd0, label_seen: 1'b0,
		cont: 1'b0, delim: 8'd0, esc: 1'b0, hcount: 32'd0, hovf: 1'b0,
		hrem: 32'd0, first: 1'b1, halted: 1'b0, live: 1'b0
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [31:0] label_number;
		logic [1:0] error_code;
		logic last;
	} res_t;

	typedef struct packed {
		logic [7:0] column_limit;
		logic tab_form;
		logic debug_lines;
	} cfg_t;

	function automatic logic is_h(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT;
	endfunction

	function automatic logic is_v(input logic [7:0] c);
		return c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic is_d(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	// value * 10 + digit, widened by a 4-bit carry-out nibble for overflow checks
	function automatic logic [35:0] mul10_add(input logic [31:0] v, input logic [7:0] c);
		logic [35:0] w;
		w = {4'd0, v};
		return (w << 3) + (w << 1) + {32'd0, c[3:0]};
	endfunction

endpackage

// ===== src/fixed_form_source_normalizer.sv =====
// Fixed-form source normalizer: turns fixed-form or tab-form source bytes into a code stream
// with label marks, statement newlines and label errors. One source byte is accepted per
// cycle while in_stall is low: a byte is captured in the input register; once the queue has
// room for a full burst, its line state is advanced and its zero to three results go to a
// four-entry result queue, which hands out one result per cycle unless out_stall is high.
// Bytes giving one result or none keep that rate; others are limited by the output side. A
// NUL byte clears all line state and gives no result; after a label error the block drops
// every byte up to the next NUL. Configuration must be written while the block is idle.
module fixed_form_source_normalizer
	import ffsn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [7:0]  wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  src_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [31:0] label_number,
	output logic [1:0]  error_code,
	output logic        last
);

	cfg_t cfg_q;
	st_t st_q;
	st_t st_nxt;
	logic [7:0] byte_s1;
	logic vld_s1;
	logic room;
	logic fire;
	logic pop;
	logic not_empty;
	logic [1:0] res_n;
	res_t res [MAX_RES];
	res_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{column_limit: COLUMN_LIMIT_RST, tab_form: 1'b0, debug_lines: 1'b0};
		end else if (wr_en) begin
			unique case (wr_index)
				REG_COLUMN_LIMIT: cfg_q.column_limit <= wr_data;
				REG_TAB_FORM:     cfg_q.tab_form <= wr_data[0];
				REG_DEBUG_LINES:  cfg_q.debug_lines <= wr_data[0];
				default: ;
			endcase
		end
	end

	// process the held byte once the queue can take a full burst
	assign fire = vld_s1 && room;
	assign in_stall = vld_s1 && !room;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= src_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			st_q <= ST_CLEAR;
		end else begin
			if (in_valid && !in_stall)
				vld_s1 <= 1'b1;
			else if (fire)
				vld_s1 <= 1'b0;
			if (fire)
				st_q <= st_nxt;
		end
	end

	ffsn_step u_step (
		.st_cur (st_q),
		.c      (byte_s1),
		.cfg    (cfg_q),
		.st_nxt (st_nxt),
		.res    (res),
		.res_n  (res_n)
	);

	assign pop = not_empty && !out_stall;

	ffsn_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (fire ? res_n : 2'd0),
		.push_data (res),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.room      (room)
	);

	assign out_valid = not_empty;
	assign kind = head.kind;
	assign out_byte = head.out_byte;
	assign label_number = head.label_number;
	assign error_code = head.error_code;
	assign last = head.last;

endmodule

// ===== src/ffsn_step.sv =====
// Per-byte next-state and result logic of the fixed-form source normalizer.
module ffsn_step
	import ffsn_pkg::*;
(
	input  st_t        st_cur,
	input  logic [7:0] c,
	input  cfg_t       cfg,
	output st_t        st_nxt,
	output res_t       res [MAX_RES],
	output logic [1:0] res_n
);

	function automatic st_t f_wipe(input st_t si);
		st_t so;
		so = si;
		so.delim = 8'd0;
		so.esc = 1'b0;
		so.hcount = 32'd0;
		so.hovf = 1'b0;
		so.hrem = 32'd0;
		return so;
	endfunction

	function automatic st_t f_new_line(input st_t si);
		st_t so;
		so = si;
		so.column = 8'd0;
		so.phase = PH_LABEL;
		so.live = 1'b0;
		so.label_seen = 1'b0;
		so.label_accum = 32'd0;
		return so;
	endfunction

	function automatic st_t f_settle(input st_t si, output logic lbl);
		st_t so;
		so = si;
		lbl = 1'b0;
		if (!si.cont) begin
			lbl = si.label_seen;
			so = f_wipe(si);
		end
		return so;
	endfunction

	function automatic st_t f_finish(input st_t si, input logic cont, input logic keep,
			output logic lbl);
		st_t so;
		so = si;
		lbl = 1'b0;
		if (!keep)
			so.label_seen = 1'b0;
		so.cont = cont;
		so.phase = PH_SKIP;
		if (so.live)
			so = f_settle(so, lbl);
		return so;
	endfunction

	// one code byte: string, Hollerith, comment and blank handling
	function automatic st_t f_code(input st_t si, input logic [7:0] ch,
			output logic emit, output logic eol);
		st_t so;
		logic fin;
		logic skip;
		logic [35:0] n;
		so = si;
		fin = is_v(ch);
		skip = 1'b0;
		n = mul10_add(si.hcount, ch);
		if (si.hrem != 32'd0) begin
			so.hrem = si.hrem - 32'd1;
		end else if (si.delim != 8'd0) begin
			if (ch == si.delim && !si.esc)
				so.delim = 8'd0;
			so.esc = (ch == CH_BSLASH);
		end else begin
			if (ch == CH_BANG) begin
				fin = 1'b1;
			end else if (ch == CH_QUOTE || ch == CH_DQUOTE) begin
				so.delim = ch;
				so.esc = 1'b0;
			end
			if (ch == CH_UH || ch == CH_LH) begin
				if (!si.hovf)
					so.hrem = si.hcount;
			end else if (is_d(ch)) begin
				if (n[35:32] != 4'd0)
					so.hovf = 1'b1;
				else
					so.hcount = n[31:0];
			end else begin
				so.hovf = 1'b0;
				so.hcount = 32'd0;
			end
			skip = is_h(ch);
		end
		eol = fin;
		emit = !fin && !skip;
		return so;
	endfunction

	st_t s;
	logic done;
	logic e_lbl;
	logic e_nl;
	logic e_code;
	logic e_err;
	logic lb;
	logic ce;
	logic eol;
	logic [1:0] ecode;
	logic [31:0] lval;
	logic [7:0] col;
	logic [35:0] ln;
	logic [1:0] n;

	always_comb begin
		s = st_cur;
		done = 1'b0;
		e_lbl = 1'b0;
		e_nl = 1'b0;
		e_code = 1'b0;
		e_err = 1'b0;
		lb = 1'b0;
		ce = 1'b0;
		eol = 1'b0;
		ecode = ERR_NONE;
		lval = 32'd0;
		col = st_cur.column;
		ln = mul10_add(st_cur.label_accum, c);

		if (c == CH_NUL) begin
			s = ST_CLEAR;
		end else if (st_cur.halted) begin
			s = st_cur;
		end else if (is_v(c)) begin
			if (s.phase == PH_CODE) begin
				if (col < cfg.column_limit)
					s = f_code(s, c, ce, eol);
			end else if ((s.phase == PH_LABEL || s.phase == PH_CONT) && s.live) begin
				s = f_finish(s, 1'b0, cfg.tab_form && s.phase == PH_CONT, lb);
				if (lb) begin
					e_lbl = 1'b1;
					lval = s.label_accum;
				end
			end
			s = f_new_line(s);
		end else begin
			s.column = (col < 8'd255) ? col + 8'd1 : 8'd255;
			if (s.phase == PH_IGNORE) begin
				done = 1'b1;
			end else if (s.phase == PH_CODE) begin
				done = 1'b1;
				if (col >= cfg.column_limit) begin
					s.phase = PH_IGNORE;
				end else begin
					s = f_code(s, c, ce, eol);
					e_code = ce;
					if (eol)
						s.phase = PH_IGNORE;
				end
			end else if (!s.live) begin
				if (col == 8'd0 && (c == CH_UC || c == CH_LC || c == CH_STAR ||
						c == CH_BANG || (cfg.debug_lines && (c == CH_UD || c == CH_LD)))) begin
					s.phase = PH_IGNORE;
					done = 1'b1;
				end else if (col >= cfg.column_limit) begin
					s.phase = PH_IGNORE;
					done = 1'b1;
				end else if (!is_h(c)) begin
					if (c == CH_BANG) begin
						s.phase = PH_IGNORE;
						done = 1'b1;
					end else begin
						s.live = 1'b1;
						if (s.phase == PH_SKIP) begin
							s = f_settle(s, lb);
							if (lb) begin
								e_lbl = 1'b1;
								lval = s.label_accum;
							end
						end
					end
				end
			end

			if (!done) begin
				if (s.phase == PH_LABEL && !cfg.tab_form && col >= 8'(LABEL_COLUMNS))
					s.phase = PH_CONT;
				if (s.phase == PH_LABEL) begin
					if (col == 8'd0 && (c == CH_UD || c == CH_LD) && !cfg.debug_lines) begin
						done = 1'b1;
					end else if (cfg.tab_form && c == CH_TAB) begin
						s.phase = PH_CONT;
						done = 1'b1;
					end else if (is_d(c)) begin
						done = 1'b1;
						if (cfg.tab_form && ln[35:32] != 4'd0) begin
							e_err = 1'b1;
							ecode = ERR_LABEL_BIG;
							s.halted = 1'b1;
						end else begin
							s.label_accum = ln[31:0];
							s.label_seen = 1'b1;
						end
					end else if (is_h(c)) begin
						done = 1'b1;
					end else if (c != CH_BANG) begin
						e_err = 1'b1;
						ecode = ERR_BAD_LABEL;
						s.halted = 1'b1;
						done = 1'b1;
					end else begin
						s = f_finish(s, 1'b0, 1'b0, lb);
					end
				end else if (s.phase == PH_CONT) begin
					if (cfg.tab_form) begin
						if (is_d(c) && c != CH_0) begin
							s = f_finish(s, 1'b1, 1'b1, lb);
							done = 1'b1;
						end else begin
							s = f_finish(s, 1'b0, 1'b1, lb);
						end
					end else if (c == CH_BANG) begin
						s = f_finish(s, 1'b0, 1'b0, lb);
					end else begin
						s = f_finish(s, !is_h(c) && c != CH_0, 1'b1, lb);
						done = 1'b1;
					end
				end
				if (lb) begin
					e_lbl = 1'b1;
					lval = s.label_accum;
				end
			end

			if (!done) begin
				if (is_h(c)) begin
					done = 1'b1;
				end else if ((s.delim == 8'd0 && s.hrem == 32'd0 && c == CH_BANG) ||
						col >= cfg.column_limit) begin
					s.phase = PH_IGNORE;
				end else begin
					if (!s.first && !s.cont)
						e_nl = 1'b1;
					s.first = 1'b0;
					s.phase = PH_CODE;
					s = f_code(s, c, ce, eol);
					e_code = ce;
					if (eol)
						s.phase = PH_IGNORE;
				end
			end
		end
		st_nxt = s;
	end

	// pack results in emission order: label mark, newline, code byte, error
	always_comb begin
		for (int k = 0; k < MAX_RES; k++)
			res[k] = '0;
		n = 2'd0;
		if (e_lbl) begin
			res[n] = '{kind: KIND_LABEL, out_byte: 8'd0, label_number: lval,
				error_code: ERR_NONE, last: 1'b0};
			n = n + 2'd1;
		end
		if (e_nl) begin
			res[n] = '{kind: KIND_NEWLINE, out_byte: NEWLINE_BYTE, label_number: 32'd0,
				error_code: ERR_NONE, last: 1'b0};
			n = n + 2'd1;
		end
		if (e_code) begin
			res[n] = '{kind: KIND_CODE, out_byte: c, label_number: 32'd0,
				error_code: ERR_NONE, last: 1'b0};
			n = n + 2'd1;
		end
		if (e_err) begin
			res[n] = '{kind: KIND_ERROR, out_byte: 8'd0, label_number: 32'd0,
				error_code: ecode, last: 1'b0};
			n = n + 2'd1;
		end
		if (n != 2'd0)
			res[n - 2'd1].last = 1'b1;
		res_n = n;
	end

endmodule

// ===== src/ffsn_resq.sv =====
// Result queue: takes up to three results per cycle, hands out one per cycle while pop is high.
module ffsn_resq
	import ffsn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  res_t       push_data [MAX_RES],
	input  logic       pop,
	output res_t       head,
	output logic       not_empty,
	output logic       room
);

	res_t entry_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;

	assign head = entry_q[rd_q];
	assign not_empty = (cnt_q != '0);
	// room for a full burst of results
	assign room = (cnt_q <= QCW'(QDEPTH - MAX_RES));

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RES; k++) begin
			if (k < int'(push_n))
				entry_q[QAW'(wr_q + QAW'(k))] <= push_data[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= QAW'(wr_q + QAW'(push_n));
			if (pop)
				rd_q <= QAW'(rd_q + QAW'(1));
			cnt_q <= QCW'(cnt_q + QCW'(push_n) - QCW'(pop));
		end
	end

endmodule

// ===== src/ffsn_chk.sv =====
// Port-level checker of the fixed-form source normalizer and its bind.
module ffsn_chk
	import ffsn_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [7:0]  out_byte,
	input logic [31:0] label_number,
	input logic [1:0]  error_code,
	input logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(kind) && $stable(out_byte) &&
			$stable(label_number) && $stable(error_code) && $stable(last))
		else $error("stalled result item changed");

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |->
			last && (error_code == ERR_BAD_LABEL || error_code == ERR_LABEL_BIG))
		else $error("error item malformed or not final");

	a_code_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CODE |-> last && error_code == ERR_NONE)
		else $error("code byte not the final item of its source byte");

	a_newline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_NEWLINE |->
			out_byte == NEWLINE_BYTE && !last && label_number == 32'd0)
		else $error("statement newline malformed");

endmodule

bind fixed_form_source_normalizer ffsn_chk u_ffsn_chk (.*);
